@@ src/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, codes and types of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int OUT_W     = 16;
   localparam int GAIN_W    = FRAC_BITS + 1;
   localparam int STEPS     = GAIN_W;
   localparam int CNT_W     = $clog2(STEPS);
   localparam int CSR_IDX_W = 2;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int NEXT_W    = DATA_W + 2;
   localparam int PC_W      = DIFF_W + GAIN_W;
   localparam int PU_W      = DATA_W + GAIN_W;

   localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(STEPS - 1);

   localparam logic [DATA_W-1:0] Q_RESET = DATA_W'(655);
   localparam logic [DATA_W-1:0] R_RESET = DATA_W'(65536);
   localparam logic [DATA_W-1:0] P_RESET = DATA_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Q_NOISE   = 2'd0,
      CSR_R_NOISE   = 2'd1,
      CSR_P_INITIAL = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_MEASURE = 1'b0,
      REQ_SET     = 1'b1
   } req_kind_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_PRED = 8'b0000_0010,
      S_DEN  = 8'b0000_0100,
      S_DIV  = 8'b0000_1000,
      S_GAIN = 8'b0001_0000,
      S_MUL  = 8'b0010_0000,
      S_UPD  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic set_est;
      logic pred;
      logic den;
      logic div_step;
      logic gain_setup;
      logic mul_step;
      logic update;
      logic emit;
   } cmd_type;

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
   endfunction

endpackage

@@ src/skf_ctrl.sv @@
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer of the filter: steps the datapath through prediction, gain
// division, the two shift-add products, the update and the result hand-off.
// ----------------------------------------------------------------------------
module skf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_type,
   output logic             req_stall,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output skf_pkg::cmd_type cmd
);

   skf_pkg::state_type           state_ff, state_in;
   logic [skf_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;
   logic                         cnt_last;
   logic                         rsp_free;

   assign accept    = req_valid && (state_ff == skf_pkg::S_IDLE);
   assign cnt_last  = (cnt_ff == skf_pkg::CNT_LAST);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != skf_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         skf_pkg::S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (skf_pkg::req_kind_type'(req_type) == skf_pkg::REQ_SET) begin
                  cmd.set_est = 1'b1;
               end else begin
                  state_in = skf_pkg::S_PRED;
               end
            end
         end
         skf_pkg::S_PRED: begin
            cmd.pred = 1'b1;
            state_in = skf_pkg::S_DEN;
         end
         skf_pkg::S_DEN: begin
            cmd.den  = 1'b1;
            state_in = skf_pkg::S_DIV;
         end
         skf_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_last) begin
               state_in = skf_pkg::S_GAIN;
            end
         end
         skf_pkg::S_GAIN: begin
            cmd.gain_setup = 1'b1;
            state_in       = skf_pkg::S_MUL;
         end
         skf_pkg::S_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_last) begin
               state_in = skf_pkg::S_UPD;
            end
         end
         skf_pkg::S_UPD: begin
            cmd.update = 1'b1;
            state_in   = skf_pkg::S_OUT;
         end
         skf_pkg::S_OUT: begin
            if (rsp_free) begin
               cmd.emit = 1'b1;
               state_in = skf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skf_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cnt_in = '0;
      if ((state_ff == skf_pkg::S_DIV || state_ff == skf_pkg::S_MUL) && !cnt_last) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_after_update: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (state_ff == skf_pkg::S_OUT))
      else $error("update not followed by result stage");

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::S_GAIN || state_ff == skf_pkg::S_UPD) |-> (cnt_ff == '0))
      else $error("step counter not cleared after iteration");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && !$past(cmd.emit))
      else $error("pending item overwritten");
`endif

endmodule

@@ src/skf_datapath.sv @@
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, noise registers, restoring gain divider and two shift-add
// multipliers sharing one step counter in the sequencer.
// ----------------------------------------------------------------------------
module skf_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  skf_pkg::cmd_type                   cmd,
   input  logic signed [skf_pkg::DATA_W-1:0]  req_sample_value,
   input  logic                               csr_wr_en,
   input  logic [skf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [skf_pkg::DATA_W-1:0]         csr_wdata,
   output logic signed [skf_pkg::OUT_W-1:0]   rsp_filtered_value
);

   localparam int DW = skf_pkg::DATA_W;
   localparam int GW = skf_pkg::GAIN_W;
   localparam int FB = skf_pkg::FRAC_BITS;
   localparam int OW = skf_pkg::OUT_W;

   logic [DW-1:0]               q_ff, r_ff;
   logic [DW-1:0]               est_ff, est_in;
   logic [DW-1:0]               unc_ff;
   logic [DW-1:0]               sample_ff;
   logic [DW-1:0]               pp_ff;
   logic [DW-1:0]               den_ff;
   logic [skf_pkg::DIFF_W-1:0]  diff_ff;
   logic [skf_pkg::DIFF_W-1:0]  rem_ff, rem_sub;
   logic [GW-1:0]               gain_ff;
   logic [skf_pkg::DIFF_W-1:0]  mag_ff, diff_abs;
   logic [GW-1:0]               mulg_ff, ngain_ff;
   logic [skf_pkg::PC_W-1:0]    accc_ff;
   logic [skf_pkg::PU_W-1:0]    accu_ff;
   logic [OW-1:0]               rsp_ff, rsp_in;
   logic                        den_zero, rem_ge;
   logic [skf_pkg::NEXT_W-1:0]  corr_mag, corr, next_sum;
   logic                        sat_hi, sat_lo;
   logic                        csr_p_wr;
   logic [DW-1:0]               est_abs, ip_mag;

   assign den_zero = (den_ff == '0);
   assign rem_ge   = !den_zero && (rem_ff >= {1'b0, den_ff});
   assign rem_sub  = rem_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   assign diff_abs = diff_ff[skf_pkg::DIFF_W-1] ? (~diff_ff + 1'b1) : diff_ff;
   assign csr_p_wr = csr_wr_en
                     && (skf_pkg::csr_index_type'(csr_index) == skf_pkg::CSR_P_INITIAL);

   // correction and saturated new estimate
   always_comb begin
      corr_mag = accc_ff[skf_pkg::PC_W-1:FB];
      corr     = diff_ff[skf_pkg::DIFF_W-1] ? (~corr_mag + 1'b1) : corr_mag;
      next_sum = {{2{est_ff[DW-1]}}, est_ff} + corr;
      sat_hi   = !next_sum[DW+1] && (next_sum[DW:DW-1] != 2'b00);
      sat_lo   = next_sum[DW+1] && (next_sum[DW:DW-1] != 2'b11);
      if (sat_hi) begin
         est_in = {1'b0, {(DW-1){1'b1}}};
      end else if (sat_lo) begin
         est_in = {1'b1, {(DW-1){1'b0}}};
      end else begin
         est_in = next_sum[DW-1:0];
      end
   end

   // integer part, truncated toward zero and clamped
   always_comb begin
      est_abs = est_ff[DW-1] ? (~est_ff + 1'b1) : est_ff;
      ip_mag  = est_abs >> FB;
      if (!est_ff[DW-1]) begin
         rsp_in = (ip_mag > DW'((2 ** (OW - 1)) - 1)) ? {1'b0, {(OW-1){1'b1}}}
                                                      : ip_mag[OW-1:0];
      end else begin
         rsp_in = (ip_mag > DW'(2 ** (OW - 1))) ? {1'b1, {(OW-1){1'b0}}}
                                                : (~ip_mag[OW-1:0] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff   <= skf_pkg::Q_RESET;
         r_ff   <= skf_pkg::R_RESET;
         est_ff <= '0;
         unc_ff <= skf_pkg::P_RESET;
      end else begin
         if (csr_wr_en) begin
            unique case (skf_pkg::csr_index_type'(csr_index))
               skf_pkg::CSR_Q_NOISE:   q_ff <= csr_wdata;
               skf_pkg::CSR_R_NOISE:   r_ff <= csr_wdata;
               skf_pkg::CSR_P_INITIAL: ;
               default: ;
            endcase
         end
         if (cmd.set_est) begin
            est_ff <= req_sample_value;
         end else if (cmd.update) begin
            est_ff <= est_in;
         end
         if (csr_p_wr) begin
            unc_ff <= csr_wdata;
         end else if (cmd.set_est) begin
            unc_ff <= skf_pkg::sat_add(unc_ff, q_ff);
         end else if (cmd.update) begin
            unc_ff <= accu_ff[FB +: DW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample_value;
      end
      if (cmd.pred) begin
         pp_ff <= skf_pkg::sat_add(unc_ff, q_ff);
      end
      if (cmd.den) begin
         den_ff  <= skf_pkg::sat_add(pp_ff, r_ff);
         diff_ff <= {sample_ff[DW-1], sample_ff} - {est_ff[DW-1], est_ff};
         rem_ff  <= {1'b0, pp_ff};
         gain_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= {rem_sub[DW-1:0], 1'b0};
         gain_ff <= {gain_ff[GW-2:0], rem_ge};
         mag_ff  <= diff_abs;
      end
      if (cmd.gain_setup) begin
         mulg_ff  <= gain_ff;
         ngain_ff <= skf_pkg::GAIN_ONE - gain_ff;
         accc_ff  <= '0;
         accu_ff  <= '0;
      end
      if (cmd.mul_step) begin
         accc_ff  <= {accc_ff[skf_pkg::PC_W-2:0], 1'b0}
                     + (mulg_ff[GW-1] ? skf_pkg::PC_W'(mag_ff) : '0);
         accu_ff  <= {accu_ff[skf_pkg::PU_W-2:0], 1'b0}
                     + (ngain_ff[GW-1] ? skf_pkg::PU_W'(pp_ff) : '0);
         mulg_ff  <= {mulg_ff[GW-2:0], 1'b0};
         ngain_ff <= {ngain_ff[GW-2:0], 1'b0};
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_filtered_value = rsp_ff;

`ifndef SYNTHESIS
   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.gain_setup |-> (gain_ff <= skf_pkg::GAIN_ONE))
      else $error("gain above one");

   a_zero_den_gain: assert property (@(posedge clock) disable iff (reset)
      (cmd.gain_setup && den_zero) |-> (gain_ff == '0))
      else $error("zero denominator gave non-zero gain");

   a_unc_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !csr_p_wr) |=> (unc_ff <= pp_ff))
      else $error("uncertainty grew on update");
`endif

endmodule

@@ src/scalar_kalman_filter.sv @@
// Measurement item: prediction, denominator, the 17-step restoring divider for
// the gain, gain setup, the 17-step shift-add multipliers, the update and the
// result stage; the next item is taken once the result stage has emitted.
// A set-estimate item gives no result and leaves the filter idle.
// Synchronous reset restores the noise registers to their defaults, clears the
// estimate and loads the uncertainty with the p_initial default.
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter on a stream of Q16.16 sensor values.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic signed [skf_pkg::DATA_W-1:0]  req_sample_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [skf_pkg::OUT_W-1:0]   rsp_filtered_value,
   input  logic                               csr_wr_en,
   input  logic [skf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [skf_pkg::DATA_W-1:0]         csr_wdata
);

   skf_pkg::cmd_type cmd;

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   skf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_sample_value   (req_sample_value),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_filtered_value (rsp_filtered_value)
   );

endmodule

@@ verif/scalar_kalman_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_tb
// Drives measurement and set-estimate items through the filter with random
// gaps and result back-pressure, predicts each filtered value from its own
// fixed-point copy of the filter state and checks every result in order.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_tb;
   import skf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SMALL_SPAN  = 200 << FRAC_BITS;
   localparam int IDLE_CYCLES = 60;
   localparam int DRAIN_LIMIT = 20000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 100;

   class kalman_scoreboard;
      logic [DATA_W-1:0]        q_cov;
      logic [DATA_W-1:0]        r_cov;
      logic [DATA_W-1:0]        p_start;
      logic signed [DATA_W-1:0] est_q16;
      logic [DATA_W-1:0]        unc_q16;
      logic signed [OUT_W-1:0]  estimates_due[$];
      int                       failures;

      function new();
         q_cov    = Q_RESET;
         r_cov    = R_RESET;
         p_start  = P_RESET;
         est_q16  = '0;
         unc_q16  = P_RESET;
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
         case (idx)
            CSR_Q_NOISE: begin
               q_cov = val;
            end
            CSR_R_NOISE: begin
               r_cov = val;
            end
            CSR_P_INITIAL: begin
               p_start = val;
               unc_q16 = val;
            end
            default: begin
            end
         endcase
      endfunction

      function void note_sample(req_kind_type kind, logic signed [DATA_W-1:0] sample);
         logic [63:0]        one_q, cap, pp, den, gain, mag;
         logic signed [63:0] s64, e64, diff, nxt, ip;
         one_q = 64'd1 << FRAC_BITS;
         cap   = 64'h0000_0000_FFFF_FFFF;
         pp    = 64'(unc_q16) + 64'(q_cov);
         if (pp > cap) pp = cap;
         if (kind == REQ_SET) begin
            est_q16 = sample;
            unc_q16 = pp[DATA_W-1:0];
            return;
         end
         den = pp + 64'(r_cov);
         if (den > cap) den = cap;
         gain = (den == 0) ? 64'd0 : (pp << FRAC_BITS) / den;
         if (gain > one_q) gain = one_q;
         s64  = sample;
         e64  = est_q16;
         diff = s64 - e64;
         if (diff < 0) mag = -diff;
         else mag = diff;
         mag = (gain * mag) >> FRAC_BITS;
         if (diff < 0) nxt = e64 - $signed(mag);
         else nxt = e64 + $signed(mag);
         if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
         if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
         est_q16 = nxt[DATA_W-1:0];
         unc_q16 = 32'(((one_q - gain) * pp) >> FRAC_BITS);
         if (nxt < 0) mag = -nxt;
         else mag = nxt;
         mag = mag >> FRAC_BITS;
         if (nxt < 0) ip = -$signed(mag);
         else ip = $signed(mag);
         if (ip > 64'sd32767) ip = 64'sd32767;
         if (ip < -64'sd32768) ip = -64'sd32768;
         estimates_due.push_back(ip[OUT_W-1:0]);
      endfunction

      function void check_estimate(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (estimates_due.size() == 0) begin
            $error("filtered_value: no item pending, got %0d", got);
            failures++;
            return;
         end
         want = estimates_due.pop_front();
         if (got !== want) begin
            $error("filtered_value: expected %0d, got %0d", want, got);
            failures++;
         end
      endfunction

      function int pending();
         return estimates_due.size();
      endfunction

      function void flag_leftover();
         if (estimates_due.size() != 0) begin
            $error("filtered_value: %0d expected items never arrived",
                   estimates_due.size());
            failures++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_type;
   logic signed [DATA_W-1:0]    req_sample_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [OUT_W-1:0]     rsp_filtered_value;
   logic                        csr_wr_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [DATA_W-1:0]           csr_wdata;

   kalman_scoreboard sb;
   bit               calm;
   int               hold_left;

   scalar_kalman_filter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1, 2: return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_cov();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: return $urandom_range(1, 32'h0004_0000);
      endcase
   endfunction

   // result side back-pressure
   always @(posedge clock) begin : rsp_backpressure
      int span;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         span = pick_gap();
         hold_left <= (span > 0) ? span - 1 : 0;
         rsp_stall <= (span > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_estimate(rsp_filtered_value);
         if (req_valid && !req_stall) begin
            sb.note_sample(req_kind_type'(req_type), req_sample_value);
         end
      end
   end

   task automatic send_item(input req_kind_type kind, input logic signed [DATA_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_sample_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random();
      req_kind_type kind;
      kind = ($urandom_range(0, 4) == 0) ? REQ_SET : REQ_MEASURE;
      send_item(kind, pick_sample());
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic end_writes();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // let the filter drain before touching its registers or finishing
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      sb = new();
      calm = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= REQ_MEASURE;
      req_sample_value <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_Q_NOISE;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // defaults straight out of reset
      send_item(REQ_MEASURE, 32'h0000_0000);
      send_item(REQ_MEASURE, 32'h7FFF_FFFF);
      send_item(REQ_MEASURE, 32'h8000_0000);
      send_item(REQ_SET,     32'h1234_5678);
      send_item(REQ_MEASURE, 32'h0001_8000);
      send_item(REQ_SET,     32'hFFFF_FFFF);
      send_item(REQ_MEASURE, 32'hFFFF_0000);

      // zero denominator, gain stays at nought
      settle();
      write_reg(CSR_Q_NOISE, '0);
      write_reg(CSR_R_NOISE, '0);
      write_reg(CSR_P_INITIAL, '0);
      end_writes();
      send_item(REQ_MEASURE, 32'h7FFF_FFFF);
      send_item(REQ_SET,     32'h0005_0000);
      send_item(REQ_MEASURE, 32'h8000_0000);

      // unity gain on the first item only: the estimate follows it and clips on output
      settle();
      write_reg(CSR_P_INITIAL, 32'h0000_0001);
      end_writes();
      send_item(REQ_MEASURE, 32'h7FFF_FFFF);
      send_item(REQ_MEASURE, 32'h8000_0000);
      send_item(REQ_MEASURE, 32'hFFFE_8000);

      // saturating sums, plus a write to the unused index
      settle();
      write_reg(CSR_Q_NOISE, '1);
      write_reg(CSR_R_NOISE, '1);
      write_reg(CSR_P_INITIAL, '1);
      write_reg(CSR_UNUSED, 32'h0000_0000);
      end_writes();
      send_item(REQ_MEASURE, 32'h7FFF_FFFF);
      send_item(REQ_SET,     32'h8000_0000);
      send_item(REQ_MEASURE, 32'h0000_0000);
      send_item(REQ_MEASURE, 32'h4000_0000);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_reg(CSR_Q_NOISE, pick_cov());
         write_reg(CSR_R_NOISE, pick_cov());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_P_INITIAL, pick_cov());
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, $urandom);
         end_writes();
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 24) calm = ($urandom_range(0, 3) == 0);
            send_random();
         end
      end

      calm = 1'b0;
      settle();
      sb.flag_leftover();
      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
